// ===== hw/rtl/proximity_motor_speed_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// Proximity motor speed controller - assertion macros
// Concurrent checks on the core, sampled at the rising clock edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_MOTOR_SPEED_CONTROLLER_CORE_ASSERT_SVH
`define PROXIMITY_MOTOR_SPEED_CONTROLLER_CORE_ASSERT_SVH

// check a consequent in the same cycle as its antecedent
`define PMSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmsc check failed in the same cycle");

// check a consequent in the cycle after its antecedent
`define PMSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmsc check failed one cycle later");

`endif

// ===== hw/rtl/pmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsc_pkg
// Types and constants shared by the proximity motor speed controller.
// ----------------------------------------------------------------------------
package pmsc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_LIMIT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_HOLD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_HOLD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MANEUVER_SPD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_INTERVAL = 3'd6;

    localparam logic [8:0]  RST_NEAR_LIMIT    = 9'd5;
    localparam logic [8:0]  RST_FAR_LIMIT     = 9'd60;
    localparam logic [15:0] RST_STOP_HOLD     = 16'd500;
    localparam logic [15:0] RST_REVERSE_HOLD  = 16'd200;
    localparam logic [6:0]  RST_MANEUVER_SPD  = 7'd20;
    localparam logic [6:0]  RST_DEADBAND      = 7'd3;
    localparam logic [15:0] RST_PING_INTERVAL = 16'd50;

    // echo_us / 58 as (echo_us * ECHO_RECIP) >> 21, exact for 15-bit echoes
    localparam logic [15:0] ECHO_RECIP = 16'd36158;
    localparam logic [9:0]  MIN_CM     = 10'd2;
    localparam logic [9:0]  MAX_CM     = 10'd400;

    localparam logic [6:0]        MAX_PERCENT   = 7'd100;
    localparam logic [6:0]        HALF_PERCENT  = 7'd50;
    localparam logic signed [7:0] FULL_SPEED    = 8'sd100;
    localparam logic [15:0]       PERCENT_SCALE = 16'd100;

    // duty = (x * 254) / 99 as ((x * 254) * DUTY_RECIP) >> 22
    localparam logic [14:0] DUTY_SCALE = 15'd254;
    localparam logic [15:0] DUTY_RECIP = 16'd42367;
    // n / 10 as (n * TENTH_RECIP) >> 11 for n up to 50
    localparam logic [7:0]  TENTH_RECIP = 8'd205;
    localparam logic [7:0]  LED_FULL    = 8'd255;
    localparam logic [7:0]  LED_STEP    = 8'd5;

    localparam int unsigned DIV_STEPS = 16;

    typedef enum logic [1:0] {
        MODE_CRUISE  = 2'd0,
        MODE_STOP    = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_SLOW    = 2'd3
    } mode_t;

    typedef enum logic {
        SPD_FIXED,
        SPD_SCALED
    } spd_kind_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_CLASSIFY
    } front_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_MAP,
        BACK_FINISH
    } back_state_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [14:0] echo_us;
    } in_item_t;

    typedef struct packed {
        logic [8:0]        distance_cm;
        logic              pinged;
        mode_t             mode;
        logic signed [7:0] speed_percent;
        logic [7:0]        forward_pwm;
        logic [7:0]        reverse_pwm;
        logic              drive_changed;
        logic [7:0]        led_red;
        logic [7:0]        led_green;
    } out_item_t;

    typedef struct packed {
        logic [8:0]  near_limit_cm;
        logic [8:0]  far_limit_cm;
        logic [15:0] stop_hold_ms;
        logic [15:0] reverse_hold_ms;
        logic [6:0]  maneuver_speed;
        logic [6:0]  deadband_percent;
        logic [15:0] ping_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [8:0]        distance_cm;
        logic              pinged;
        mode_t             mode;
        spd_kind_t         kind;
        logic signed [7:0] spd_fixed;
        logic [15:0]       num;
        logic [8:0]        den;
    } job_t;

endpackage

// ===== hw/rtl/proximity_motor_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// proximity_motor_speed_controller_core
// Obstacle-aware motor speed controller: one result per control tick.
// ----------------------------------------------------------------------------
// channel  | role   | handshake          | payload
// cfg      | write  | cfg_we             | cfg_index, cfg_data
// in       | sink   | in_valid/in_ready  | in_item (time_ms, echo_us)
// out      | source | out_valid/out_ready| out_item (distance .. led_green)
//
// The front takes no new tick until its last one is in the queue; the back
// runs idle, map and finish per tick, with its 16-step divider when scaled.
// A 2-entry queue and the output register let either side stall alone.
// Reset loads the register defaults, clears the control state and sets the last speed to full, at once.
// ----------------------------------------------------------------------------
module proximity_motor_speed_controller_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pmsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pmsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pmsc_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pmsc_pkg::out_item_t                 out_item
);

`include "proximity_motor_speed_controller_core_assert.svh"

    pmsc_pkg::cfg_t cfg_reg;
    logic           push_valid;
    logic           push_ready;
    pmsc_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    pmsc_pkg::job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit_cm    <= pmsc_pkg::RST_NEAR_LIMIT;
            cfg_reg.far_limit_cm     <= pmsc_pkg::RST_FAR_LIMIT;
            cfg_reg.stop_hold_ms     <= pmsc_pkg::RST_STOP_HOLD;
            cfg_reg.reverse_hold_ms  <= pmsc_pkg::RST_REVERSE_HOLD;
            cfg_reg.maneuver_speed   <= pmsc_pkg::RST_MANEUVER_SPD;
            cfg_reg.deadband_percent <= pmsc_pkg::RST_DEADBAND;
            cfg_reg.ping_interval_ms <= pmsc_pkg::RST_PING_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pmsc_pkg::CFG_NEAR_LIMIT:    cfg_reg.near_limit_cm    <= cfg_data[8:0];
                pmsc_pkg::CFG_FAR_LIMIT:     cfg_reg.far_limit_cm     <= cfg_data[8:0];
                pmsc_pkg::CFG_STOP_HOLD:     cfg_reg.stop_hold_ms     <= cfg_data;
                pmsc_pkg::CFG_REVERSE_HOLD:  cfg_reg.reverse_hold_ms  <= cfg_data;
                pmsc_pkg::CFG_MANEUVER_SPD:  cfg_reg.maneuver_speed   <= cfg_data[6:0];
                pmsc_pkg::CFG_DEADBAND:      cfg_reg.deadband_percent <= cfg_data[6:0];
                pmsc_pkg::CFG_PING_INTERVAL: cfg_reg.ping_interval_ms <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pmsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    pmsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    pmsc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .deadband_percent (cfg_reg.deadband_percent),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_job          (pop_job),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item)
    );

    `PMSC_ASSERT_SAME(a_pwm_one_side, out_valid, (out_item.forward_pwm == 8'd0) || (out_item.reverse_pwm == 8'd0))
    `PMSC_ASSERT_SAME(a_stop_is_still, out_valid && (out_item.mode == pmsc_pkg::MODE_STOP), (out_item.speed_percent == 8'sd0) && (out_item.forward_pwm == 8'd0) && (out_item.reverse_pwm == 8'd0))
    `PMSC_ASSERT_SAME(a_speed_range, out_valid, (out_item.speed_percent <= 8'sd100) && (out_item.speed_percent >= -8'sd100))
    `PMSC_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready)

endmodule

// ===== hw/rtl/pmsc_front.sv =====
// ----------------------------------------------------------------------------
// pmsc_front
// Takes one control tick, samples the echo, runs the manoeuvre state and
// hands a classified job to the queue.
// ----------------------------------------------------------------------------
module pmsc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pmsc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pmsc_pkg::in_item_t in_item,
    output logic              push_valid,
    input  logic              push_ready,
    output pmsc_pkg::job_t    push_job
);

    pmsc_pkg::front_state_t state_reg, state_next;
    pmsc_pkg::mode_t        mode_reg, mode_next;
    logic [31:0]            time_reg;
    logic [14:0]            echo_reg;
    logic [31:0]            mode_start_reg, mode_start_next;
    logic [31:0]            last_ping_reg;
    logic [8:0]             held_dist_reg;

    logic [30:0]       echo_prod;
    logic [9:0]        echo_cm;
    logic [8:0]        sample_cm;
    logic [31:0]       ping_elapsed;
    logic [31:0]       mode_elapsed;
    logic              do_ping;
    logic [8:0]        range_cm;
    logic              near_hit;
    logic [6:0]        msp;
    logic signed [7:0] msp_s;
    logic [8:0]        offset;
    logic              full_speed;
    logic              push_fire;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmsc_pkg::FRONT_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pmsc_pkg::FRONT_CLASSIFY;
                end
            end
            pmsc_pkg::FRONT_CLASSIFY:
            begin
                if (push_ready)
                begin
                    state_next = pmsc_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = pmsc_pkg::FRONT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == pmsc_pkg::FRONT_IDLE);
        push_valid = (state_reg == pmsc_pkg::FRONT_CLASSIFY);
    end

    assign push_fire = push_valid && push_ready;

    always_comb
    begin
        echo_prod    = 31'(echo_reg) * 31'(pmsc_pkg::ECHO_RECIP);
        echo_cm      = echo_prod[30:21];
        sample_cm    = ((echo_reg != 15'd0) && (echo_cm >= pmsc_pkg::MIN_CM)
                        && (echo_cm <= pmsc_pkg::MAX_CM)) ? echo_cm[8:0] : 9'd0;
        ping_elapsed = time_reg - last_ping_reg;
        mode_elapsed = time_reg - mode_start_reg;
        do_ping      = (ping_elapsed >= {16'd0, cfg.ping_interval_ms});
        range_cm     = do_ping ? sample_cm : held_dist_reg;
        near_hit     = (range_cm != 9'd0) && (range_cm <= cfg.near_limit_cm);
        msp          = (cfg.maneuver_speed > pmsc_pkg::MAX_PERCENT)
                       ? pmsc_pkg::MAX_PERCENT : cfg.maneuver_speed;
        msp_s        = $signed({1'b0, msp});
        offset       = range_cm - cfg.near_limit_cm;
        full_speed   = (range_cm == 9'd0) || (range_cm >= cfg.far_limit_cm)
                       || (cfg.far_limit_cm <= cfg.near_limit_cm)
                       || (range_cm < cfg.near_limit_cm);
    end

    always_comb
    begin
        mode_next            = mode_reg;
        mode_start_next      = mode_start_reg;
        push_job.distance_cm = range_cm;
        push_job.pinged      = do_ping;
        push_job.kind        = pmsc_pkg::SPD_FIXED;
        push_job.spd_fixed   = 8'sd0;
        push_job.num         = 16'(offset) * pmsc_pkg::PERCENT_SCALE;
        push_job.den         = cfg.far_limit_cm - cfg.near_limit_cm;
        if (near_hit)
        begin
            unique case (mode_reg)
                pmsc_pkg::MODE_CRUISE:
                begin
                    mode_next       = pmsc_pkg::MODE_STOP;
                    mode_start_next = time_reg;
                end
                pmsc_pkg::MODE_STOP:
                begin
                    if (mode_elapsed >= {16'd0, cfg.stop_hold_ms})
                    begin
                        mode_next       = pmsc_pkg::MODE_REVERSE;
                        mode_start_next = time_reg;
                    end
                end
                pmsc_pkg::MODE_REVERSE:
                begin
                    push_job.spd_fixed = -msp_s;
                    if (mode_elapsed >= {16'd0, cfg.reverse_hold_ms})
                    begin
                        mode_next       = pmsc_pkg::MODE_SLOW;
                        mode_start_next = time_reg;
                    end
                end
                pmsc_pkg::MODE_SLOW:
                begin
                    push_job.spd_fixed = msp_s;
                    if (range_cm > cfg.far_limit_cm)
                    begin
                        mode_next = pmsc_pkg::MODE_CRUISE;
                    end
                end
                default:
                begin
                    mode_next = pmsc_pkg::MODE_CRUISE;
                end
            endcase
        end
        else
        begin
            mode_next       = pmsc_pkg::MODE_CRUISE;
            mode_start_next = time_reg;
            if (full_speed)
            begin
                push_job.spd_fixed = pmsc_pkg::FULL_SPEED;
            end
            else
            begin
                push_job.kind = pmsc_pkg::SPD_SCALED;
            end
        end
        push_job.mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmsc_pkg::FRONT_IDLE;
            mode_reg       <= pmsc_pkg::MODE_CRUISE;
            mode_start_reg <= 32'd0;
            last_ping_reg  <= 32'd0;
            held_dist_reg  <= 9'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (push_fire)
            begin
                mode_reg       <= mode_next;
                mode_start_reg <= mode_start_next;
                if (do_ping)
                begin
                    last_ping_reg <= time_reg;
                    held_dist_reg <= sample_cm;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            time_reg <= in_item.time_ms;
            echo_reg <= in_item.echo_us;
        end
    end

endmodule

// ===== hw/rtl/pmsc_queue.sv =====
// ----------------------------------------------------------------------------
// pmsc_queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module pmsc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  pmsc_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pmsc_pkg::job_t pop_job
);

    localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    pmsc_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               push_fire;
    logic               pop_fire;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/pmsc_back.sv =====
// ----------------------------------------------------------------------------
// pmsc_back
// Works out the speed of a job (serial divide where scaled), applies the
// deadband and maps the result to PWM duty and LED levels.
// ----------------------------------------------------------------------------
module pmsc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          deadband_percent,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  pmsc_pkg::job_t      pop_job,
    output logic                out_valid,
    input  logic                out_ready,
    output pmsc_pkg::out_item_t out_item
);

    localparam int unsigned STEP_W = $clog2(pmsc_pkg::DIV_STEPS);

    pmsc_pkg::back_state_t state_reg, state_next;
    pmsc_pkg::job_t        job_reg;
    logic [15:0]           quot_reg;
    logic [8:0]            rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic signed [7:0]     spd_reg;
    logic [6:0]            mag_reg;
    logic                  db_zero_reg;
    logic [14:0]           duty_prod_reg;
    logic signed [7:0]     prev_speed_reg;
    logic                  out_valid_reg;
    pmsc_pkg::out_item_t   out_item_reg;

    logic [9:0]        rem_shift;
    logic              rem_ge;
    logic signed [7:0] spd_sel;
    logic [6:0]        mag_sel;
    logic [30:0]       duty_full;
    logic [7:0]        duty;
    logic              led_low;
    logic [6:0]        led_n;
    logic [14:0]       tenth_prod;
    logic [7:0]        led_ramp;
    logic signed [7:0] db_speed;
    logic              pop_fire;
    logic              load_out;
    pmsc_pkg::out_item_t result;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmsc_pkg::BACK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = (pop_job.kind == pmsc_pkg::SPD_SCALED)
                                 ? pmsc_pkg::BACK_DIV : pmsc_pkg::BACK_MAP;
                end
            end
            pmsc_pkg::BACK_DIV:
            begin
                if (step_reg == STEP_W'(pmsc_pkg::DIV_STEPS - 1))
                begin
                    state_next = pmsc_pkg::BACK_MAP;
                end
            end
            pmsc_pkg::BACK_MAP:
            begin
                state_next = pmsc_pkg::BACK_FINISH;
            end
            pmsc_pkg::BACK_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = pmsc_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = pmsc_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == pmsc_pkg::BACK_IDLE);
        load_out  = (state_reg == pmsc_pkg::BACK_FINISH) && (!out_valid_reg || out_ready);
    end

    assign pop_fire  = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[15]};
        rem_ge    = (rem_shift >= {1'b0, job_reg.den});
        spd_sel   = (job_reg.kind == pmsc_pkg::SPD_SCALED)
                    ? $signed({quot_reg[7:1], 1'b0}) : job_reg.spd_fixed;
        mag_sel   = spd_sel[7] ? 7'(-spd_sel) : spd_sel[6:0];
    end

    always_comb
    begin
        duty_full  = 31'(duty_prod_reg) * 31'(pmsc_pkg::DUTY_RECIP);
        duty       = duty_full[29:22] + 8'd1;
        led_low    = (mag_reg <= pmsc_pkg::HALF_PERCENT);
        led_n      = led_low ? mag_reg : (pmsc_pkg::MAX_PERCENT - mag_reg);
        tenth_prod = 15'(led_n) * 15'(pmsc_pkg::TENTH_RECIP);
        led_ramp   = 8'(led_n) * pmsc_pkg::LED_STEP + 8'(tenth_prod[14:11]);
        db_speed   = db_zero_reg ? 8'sd0 : spd_reg;

        result.distance_cm   = job_reg.distance_cm;
        result.pinged        = job_reg.pinged;
        result.mode          = job_reg.mode;
        result.speed_percent = spd_reg;
        result.forward_pwm   = (!db_zero_reg && !spd_reg[7]) ? duty : 8'd0;
        result.reverse_pwm   = (!db_zero_reg && spd_reg[7]) ? duty : 8'd0;
        result.drive_changed = (db_speed != prev_speed_reg);
        result.led_red       = led_low ? pmsc_pkg::LED_FULL : led_ramp;
        result.led_green     = led_low ? led_ramp : pmsc_pkg::LED_FULL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmsc_pkg::BACK_IDLE;
            prev_speed_reg <= pmsc_pkg::FULL_SPEED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                prev_speed_reg <= spd_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            job_reg  <= pop_job;
            quot_reg <= pop_job.num;
            rem_reg  <= 9'd0;
            step_reg <= '0;
        end
        else if (state_reg == pmsc_pkg::BACK_DIV)
        begin
            quot_reg <= {quot_reg[14:0], rem_ge};
            rem_reg  <= rem_ge ? 9'(rem_shift - {1'b0, job_reg.den}) : rem_shift[8:0];
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == pmsc_pkg::BACK_MAP)
        begin
            spd_reg       <= spd_sel;
            mag_reg       <= mag_sel;
            db_zero_reg   <= (mag_sel < deadband_percent) || (mag_sel == 7'd0);
            duty_prod_reg <= 15'(mag_sel - 7'd1) * pmsc_pkg::DUTY_SCALE;
        end
        if (load_out)
        begin
            out_item_reg <= result;
        end
    end

endmodule

// ===== bench/proximity_motor_speed_controller_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_motor_speed_controller_core_test
// Feeds control ticks through the core with random gaps on both channels,
// predicts each result with a cycle-free model of the controller and compares
// every field. Runs a directed set under reset defaults, then approach and
// noise sequences under fixed extreme and random register settings.
// ----------------------------------------------------------------------------
module proximity_motor_speed_controller_core_test;

    localparam int unsigned ECHO_US_PER_CM = 58;
    localparam int unsigned CM_LOW         = 2;
    localparam int unsigned CM_HIGH        = 400;
    localparam int unsigned ECHO_TOP       = 32767;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned PHASE_TICKS    = 85;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [pmsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pmsc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    pmsc_pkg::in_item_t               in_item   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    pmsc_pkg::out_item_t              out_item;

    proximity_motor_speed_controller_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // controller state as the core should hold it
    pmsc_pkg::cfg_t limits = '{near_limit_cm:    pmsc_pkg::RST_NEAR_LIMIT,
                               far_limit_cm:     pmsc_pkg::RST_FAR_LIMIT,
                               stop_hold_ms:     pmsc_pkg::RST_STOP_HOLD,
                               reverse_hold_ms:  pmsc_pkg::RST_REVERSE_HOLD,
                               maneuver_speed:   pmsc_pkg::RST_MANEUVER_SPD,
                               deadband_percent: pmsc_pkg::RST_DEADBAND,
                               ping_interval_ms: pmsc_pkg::RST_PING_INTERVAL};
    pmsc_pkg::mode_t drive_mode = pmsc_pkg::MODE_CRUISE;
    logic [31:0] mode_since     = '0;
    logic [31:0] last_ping      = '0;
    logic [8:0]  held_cm        = '0;
    int          last_speed     = 100;

    pmsc_pkg::in_item_t  pending_ticks[$];
    pmsc_pkg::out_item_t due_results[$];
    logic [31:0] clock_ms       = '0;
    int unsigned ticks_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 1;
    int unsigned mode_seen[4]   = '{0, 0, 0, 0};
    int unsigned send_gap       = 0;
    int unsigned take_gap       = 0;
    int unsigned next_hold_at   = 250;
    bit          send_quiet     = 1'b0;
    bit          take_quiet     = 1'b0;

    function automatic pmsc_pkg::out_item_t control_tick(pmsc_pkg::in_item_t tick);
        pmsc_pkg::out_item_t r;
        logic [31:0] now;
        logic [31:0] since;
        int unsigned cm;
        int unsigned near_cm;
        int unsigned far_cm;
        int unsigned slow;
        int unsigned mag;
        int unsigned duty;
        int          spd;
        int          db;
        r       = '0;
        now     = tick.time_ms;
        near_cm = limits.near_limit_cm;
        far_cm  = limits.far_limit_cm;
        since   = now - last_ping;
        if (since >= {16'd0, limits.ping_interval_ms})
        begin
            cm = tick.echo_us / ECHO_US_PER_CM;
            if (tick.echo_us == 0 || cm < CM_LOW || cm > CM_HIGH)
                cm = 0;
            r.pinged  = 1'b1;
            last_ping = now;
            held_cm   = 9'(cm);
        end
        cm   = held_cm;
        slow = (limits.maneuver_speed > 100) ? 100 : limits.maneuver_speed;

        if (cm > 0 && cm <= near_cm)
        begin
            case (drive_mode)
                pmsc_pkg::MODE_CRUISE:
                begin
                    spd        = 0;
                    drive_mode = pmsc_pkg::MODE_STOP;
                    mode_since = now;
                end
                pmsc_pkg::MODE_STOP:
                begin
                    spd   = 0;
                    since = now - mode_since;
                    if (since >= {16'd0, limits.stop_hold_ms})
                    begin
                        drive_mode = pmsc_pkg::MODE_REVERSE;
                        mode_since = now;
                    end
                end
                pmsc_pkg::MODE_REVERSE:
                begin
                    spd   = -int'(slow);
                    since = now - mode_since;
                    if (since >= {16'd0, limits.reverse_hold_ms})
                    begin
                        drive_mode = pmsc_pkg::MODE_SLOW;
                        mode_since = now;
                    end
                end
                default:
                begin
                    spd = int'(slow);
                    if (cm > far_cm)
                        drive_mode = pmsc_pkg::MODE_CRUISE;
                end
            endcase
        end
        else
        begin
            drive_mode = pmsc_pkg::MODE_CRUISE;
            mode_since = now;
            if (cm == 0 || cm >= far_cm || far_cm <= near_cm || cm < near_cm)
                spd = 100;
            else
            begin
                spd = int'(((cm - near_cm) * 100) / (far_cm - near_cm));
                spd = (spd / 2) * 2;
                if (spd > 100)
                    spd = 100;
            end
        end

        mag = (spd < 0) ? -spd : spd;
        db  = (mag < limits.deadband_percent) ? 0 : spd;
        if (db != 0)
        begin
            duty = ((mag - 1) * 254) / 99 + 1;
            if (db > 0)
                r.forward_pwm = 8'(duty);
            else
                r.reverse_pwm = 8'(duty);
        end
        if (mag > 100)
            mag = 100;
        if (mag <= 50)
        begin
            r.led_red   = 8'd255;
            r.led_green = 8'((255 * mag) / 50);
        end
        else
        begin
            r.led_red   = 8'((255 * (100 - mag)) / 50);
            r.led_green = 8'd255;
        end

        r.distance_cm   = held_cm;
        r.mode          = drive_mode;
        r.speed_percent = 8'(spd);
        r.drive_changed = (db != last_speed);
        last_speed      = spd;
        return r;
    endfunction

    function automatic string describe(pmsc_pkg::out_item_t x);
        return $sformatf("cm=%0d ping=%0b mode=%0d spd=%0d fwd=%0d rev=%0d chg=%0b red=%0d grn=%0d",
                         x.distance_cm, x.pinged, x.mode, x.speed_percent, x.forward_pwm,
                         x.reverse_pwm, x.drive_changed, x.led_red, x.led_green);
    endfunction

    task automatic check_result(pmsc_pkg::out_item_t got);
        pmsc_pkg::out_item_t want;
        string     bad;
        mode_seen[got.mode]++;
        results_seen++;
        if (due_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %s", describe(got));
            return;
        end
        want = due_results.pop_front();
        bad  = "";
        if (got.distance_cm !== want.distance_cm)     bad = {bad, " distance_cm"};
        if (got.pinged !== want.pinged)               bad = {bad, " pinged"};
        if (got.mode !== want.mode)                   bad = {bad, " mode"};
        if (got.speed_percent !== want.speed_percent) bad = {bad, " speed_percent"};
        if (got.forward_pwm !== want.forward_pwm)     bad = {bad, " forward_pwm"};
        if (got.reverse_pwm !== want.reverse_pwm)     bad = {bad, " reverse_pwm"};
        if (got.drive_changed !== want.drive_changed) bad = {bad, " drive_changed"};
        if (got.led_red !== want.led_red)             bad = {bad, " led_red"};
        if (got.led_green !== want.led_green)         bad = {bad, " led_green"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d differs in%s\n  expected %s\n  actual   %s",
                         results_seen, bad, describe(want), describe(got));
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender: one transfer per handshake, gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                due_results.push_back(control_tick(in_item));
                ticks_sent++;
                if (ticks_sent % 50 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_ticks.pop_front();
                    send_gap = send_quiet ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: check each transfer, stall at random and hold off twice for long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_item);
                if (results_seen % 50 == 0)
                    take_quiet = ($urandom_range(0, 3) == 0);
            end
            if (results_seen == next_hold_at)
            begin
                take_gap     = LONG_HOLD;
                next_hold_at = next_hold_at + 300;
            end
            if (take_gap > 0)
            begin
                take_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                take_gap = take_quiet ? 0 : pick_gap();
            end
        end
    end

    task automatic set_reg(input logic [pmsc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pmsc_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            pmsc_pkg::CFG_NEAR_LIMIT:    limits.near_limit_cm    = value[8:0];
            pmsc_pkg::CFG_FAR_LIMIT:     limits.far_limit_cm     = value[8:0];
            pmsc_pkg::CFG_STOP_HOLD:     limits.stop_hold_ms     = value;
            pmsc_pkg::CFG_REVERSE_HOLD:  limits.reverse_hold_ms  = value;
            pmsc_pkg::CFG_MANEUVER_SPD:  limits.maneuver_speed   = value[6:0];
            pmsc_pkg::CFG_DEADBAND:      limits.deadband_percent = value[6:0];
            pmsc_pkg::CFG_PING_INTERVAL: limits.ping_interval_ms = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] near_cm, input logic [15:0] far_cm,
                                 input logic [15:0] stop_ms, input logic [15:0] rev_ms,
                                 input logic [15:0] slow, input logic [15:0] dead,
                                 input logic [15:0] ping_ms);
        set_reg(pmsc_pkg::CFG_NEAR_LIMIT, near_cm);
        set_reg(pmsc_pkg::CFG_FAR_LIMIT, far_cm);
        set_reg(pmsc_pkg::CFG_STOP_HOLD, stop_ms);
        set_reg(pmsc_pkg::CFG_REVERSE_HOLD, rev_ms);
        set_reg(pmsc_pkg::CFG_MANEUVER_SPD, slow);
        set_reg(pmsc_pkg::CFG_DEADBAND, dead);
        set_reg(pmsc_pkg::CFG_PING_INTERVAL, ping_ms);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_tick(input logic [31:0] t, input int unsigned echo);
        pmsc_pkg::in_item_t tick;
        tick.time_ms = t;
        tick.echo_us = 15'(echo);
        pending_ticks.push_back(tick);
    endtask

    function automatic int unsigned echo_for(int unsigned cm);
        int unsigned e;
        e = cm * ECHO_US_PER_CM + $urandom_range(0, ECHO_US_PER_CM - 1);
        return (e > ECHO_TOP) ? ECHO_TOP : e;
    endfunction

    task automatic advance_tick(input int unsigned echo);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            clock_ms += 10;
        else if (r < 92)
            clock_ms += $urandom_range(0, 200);
        else if (r < 98)
            clock_ms += $urandom_range(200, 5000);
        else
            clock_ms = $urandom();
        queue_tick(clock_ms, echo);
    endtask

    // mostly obstacle approaches held long enough to run the manoeuvre, some noise
    task automatic fill_phase(input int unsigned count);
        int unsigned left;
        int unsigned n;
        int unsigned k;
        int unsigned near_top;
        int unsigned cm;
        left     = count;
        near_top = (limits.near_limit_cm > CM_HIGH) ? CM_HIGH : limits.near_limit_cm;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                n = $urandom_range(12, 40);
                for (k = 0; k < n && left > 0; k++)
                begin
                    if (k >= 3 && k < n - 3)
                        cm = (near_top >= CM_LOW) ? $urandom_range(CM_LOW, near_top)
                                                  : $urandom_range(0, CM_LOW);
                    else if ($urandom_range(0, 1) == 0
                             && limits.near_limit_cm < limits.far_limit_cm)
                        cm = $urandom_range(limits.near_limit_cm, limits.far_limit_cm);
                    else
                        cm = $urandom_range(CM_LOW, 500);
                    advance_tick(echo_for(cm));
                    left--;
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n && left > 0; k++)
                begin
                    advance_tick(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, ECHO_TOP));
                    left--;
                end
            end
        end
    endtask

    task automatic finish_phase();
        do
            @(posedge clk);
        while (pending_ticks.size() != 0 || in_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: echo extremes, range edges, scaled speeds, full manoeuvre, wrap
        queue_tick(32'd0, 0);
        queue_tick(32'd50, ECHO_TOP);
        queue_tick(32'd100, 115);
        queue_tick(32'd150, 116);
        queue_tick(32'd200, 23200);
        queue_tick(32'd250, 23258);
        queue_tick(32'd300, 30000);
        queue_tick(32'd350, 30 * ECHO_US_PER_CM);
        queue_tick(32'd400, 6 * ECHO_US_PER_CM);
        queue_tick(32'd450, 7 * ECHO_US_PER_CM);
        queue_tick(32'd500, 8 * ECHO_US_PER_CM);
        queue_tick(32'd550, 59 * ECHO_US_PER_CM);
        queue_tick(32'd600, 60 * ECHO_US_PER_CM);
        queue_tick(32'd650, 3 * ECHO_US_PER_CM);
        queue_tick(32'd1150, 3 * ECHO_US_PER_CM);
        queue_tick(32'd1360, 4 * ECHO_US_PER_CM);
        queue_tick(32'd1410, 5 * ECHO_US_PER_CM);
        queue_tick(32'd1460, 0);
        queue_tick(32'hFFFF_FFF0, 100 * ECHO_US_PER_CM);
        queue_tick(32'h0000_0010, 21845);
        queue_tick(32'h0000_0030, 10922);
        clock_ms = 32'h0000_0030;
        finish_phase();

        apply_setting(30, 100, 40, 30, 25, 3, 0);
        fill_phase(PHASE_TICKS);
        finish_phase();

        apply_setting(400, 2, 0, 0, 127, 0, 0);
        fill_phase(PHASE_TICKS);
        finish_phase();

        apply_setting(0, 400, 65535, 65535, 0, 127, 65535);
        fill_phase(PHASE_TICKS);
        finish_phase();

        clock_ms = 32'hFFFF_F000;
        apply_setting(1, 2, 20, 20, 100, 100, 10);
        fill_phase(PHASE_TICKS);
        finish_phase();

        repeat (3)
        begin
            apply_setting($urandom_range(0, 120), $urandom_range(0, 511),
                          $urandom_range(0, 150), $urandom_range(0, 150),
                          $urandom_range(0, 127), $urandom_range(0, 110),
                          $urandom_range(0, 60));
            fill_phase(PHASE_TICKS);
            finish_phase();
        end

        apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        fill_phase(PHASE_TICKS);
        finish_phase();

        $display("%0d ticks under %0d register settings, %0d results checked, %0d mismatches",
                 ticks_sent, settings_used, results_seen, mismatches);
        $display("modes seen: normal %0d, stopping %0d, reversing %0d, slow forward %0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        if (mismatches == 0 && due_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
